[rtl/imhq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_pkg
// Operation and status codes of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

    // operation codes carried by an input beat
    localparam logic [1:0] FUNC_INSERT   = 2'd0;
    localparam logic [1:0] FUNC_DECREASE = 2'd1;
    localparam logic [1:0] FUNC_POP      = 2'd2;
    localparam logic [1:0] FUNC_QUERY    = 2'd3;

    // status codes carried by a result beat
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_PRESENT     = 3'd1;
    localparam logic [2:0] ST_ABSENT      = 3'd2;
    localparam logic [2:0] ST_EMPTY       = 3'd3;
    localparam logic [2:0] ST_NOT_SMALLER = 3'd4;

    // infinite weight
    localparam logic [31:0] INF_WT = 32'hFFFF_FFFF;

endpackage

[rtl/imhq_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_in_if
// Request channel: operation, node and weight, valid/ready handshake.
// ----------------------------------------------------------------------------
interface imhq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  node;
    logic [31:0] weight;

    modport source (output valid, output func, output node, output weight, input ready);
    modport sink   (input valid, input func, input node, input weight, output ready);
endinterface

[rtl/imhq_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_out_if
// Result channel: status, node, weight and queue state, valid/ready handshake.
// ----------------------------------------------------------------------------
interface imhq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  result_node;
    logic [31:0] result_weight;
    logic        present;
    logic        empty_res;
    logic [8:0]  count;

    modport source (output valid, output status, output result_node, output result_weight,
                    output present, output empty_res, output count, input ready);
    modport sink   (input valid, input status, input result_node, input result_weight,
                    input present, input empty_res, input count, output ready);
endinterface

[rtl/imhq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/indexed_min_heap_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top
// Addressable binary min-heap with insert, decrease-key, pop and query.
// ----------------------------------------------------------------------------
// One beat is handled at a time under a small sequencer; req.ready is high
// only while the sequencer is idle. The cost is set by the heap RAM port,
// which gives one entry per cycle. Query and failed operations end after
// the node's weight and position are read and checked; insert and decrease
// then climb the node, comparing it with one parent per level; pop reads
// the root and the last entry, then descends, comparing with both children
// at each level, unless it removes the last node. A finished result sits
// in an output register, so the next request is taken while it waits; a
// second result waits in the sequencer until the output register is free.
// After reset a clearing pass over all NODES entries sets every weight to
// infinity and every position to zero; no request is taken until it ends.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_top
    import imhq_pkg::*;
#(
    parameter int NODES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    imhq_in_if.sink    req,
    imhq_out_if.source rsp
);

    localparam int NW = $clog2(NODES);
    localparam int PW = $clog2(NODES + 1);
    localparam int HW = NW + 32;

    typedef enum logic [14:0] {
        S_CLEAR   = 15'b000000000000001,
        S_IDLE    = 15'b000000000000010,
        S_RD      = 15'b000000000000100,
        S_CHK     = 15'b000000000001000,
        S_UP_A    = 15'b000000000010000,
        S_UP_B    = 15'b000000000100000,
        S_POP_A   = 15'b000000001000000,
        S_POP_B   = 15'b000000010000000,
        S_POP_C   = 15'b000000100000000,
        S_DN_L    = 15'b000001000000000,
        S_DN_R    = 15'b000010000000000,
        S_DN_CMP  = 15'b000100000000000,
        S_PLACE   = 15'b001000000000000,
        S_POP_CLR = 15'b010000000000000,
        S_DONE    = 15'b100000000000000
    } state_t;

    // control registers
    state_t        state_reg, state_next;
    logic [PW-1:0] count_reg, count_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [1:0]    func_reg, func_next;
    logic [7:0]    node_reg, node_next;
    logic [31:0]   w_reg, w_next;
    logic [NW-1:0] x_node_reg, x_node_next;
    logic [31:0]   x_w_reg, x_w_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW:0]   l_reg, l_next;
    logic [NW-1:0] le_node_reg, le_node_next;
    logic [31:0]   le_w_reg, le_w_next;
    logic          has_r_reg, has_r_next;
    logic [NW-1:0] root_node_reg, root_node_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic [7:0]    res_node_reg, res_node_next;
    logic [31:0]   res_w_reg, res_w_next;
    logic          res_present_reg, res_present_next;
    logic [2:0]    o_status_reg, o_status_next;
    logic [7:0]    o_node_reg, o_node_next;
    logic [31:0]   o_w_reg, o_w_next;
    logic          o_present_reg, o_present_next;
    logic          o_empty_reg, o_empty_next;
    logic [8:0]    o_count_reg, o_count_next;

    // RAM ports
    logic          w_we, p_we, h_we;
    logic [NW-1:0] w_waddr, p_waddr, h_waddr, w_raddr, p_raddr, h_raddr;
    logic [31:0]   w_wdata, w_rdata;
    logic [PW-1:0] p_wdata, p_rdata;
    logic [HW-1:0] h_wdata, h_rdata;

    imhq_ram #(.WIDTH(32), .DEPTH(NODES)) u_weight_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    imhq_ram #(.WIDTH(PW), .DEPTH(NODES)) u_pos_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    // heap entries carry a copy of the node weight: {node, weight}
    imhq_ram #(.WIDTH(HW), .DEPTH(NODES)) u_heap_ram (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    // width helpers
    logic [NW+7:0] node_ext;
    logic [NW-1:0] node_idx;
    logic          in_range;
    logic [NW-1:0] hd_node;
    logic [31:0]   hd_w;
    logic [NW+7:0] hd_node_ext;
    logic [7:0]    hd_node8;
    logic [NW+7:0] root_ext;
    logic [PW+8:0] count_ext;
    logic [PW-1:0] p_minus1;
    logic [PW-1:0] q_pos;
    logic [PW:0]   l_pos;
    logic [PW:0]   r_pos;
    logic [PW:0]   count_wide;
    logic          r_less;
    logic [NW-1:0] s_node;
    logic [31:0]   s_w;
    logic [PW:0]   s_pos;

    assign node_ext    = {{NW{1'b0}}, node_reg};
    assign node_idx    = node_ext[NW-1:0];
    assign in_range    = node_ext < (NW + 8)'(NODES);
    assign hd_node     = h_rdata[HW-1:32];
    assign hd_w        = h_rdata[31:0];
    assign hd_node_ext = {8'd0, hd_node};
    assign hd_node8    = hd_node_ext[7:0];
    assign root_ext    = {8'd0, root_node_reg};
    assign count_ext   = {9'd0, count_reg};
    assign p_minus1    = p_reg - 1'b1;
    assign q_pos       = p_reg >> 1;
    assign l_pos       = {p_reg, 1'b0};
    assign r_pos       = l_reg + 1'b1;
    assign count_wide  = {1'b0, count_reg};
    assign r_less      = has_r_reg && (hd_w < le_w_reg);
    assign s_node      = r_less ? hd_node : le_node_reg;
    assign s_w         = r_less ? hd_w : le_w_reg;
    assign s_pos       = r_less ? r_pos : l_reg;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        clr_next         = clr_reg;
        out_valid_next   = out_valid_reg & ~rsp.ready;
        func_next        = func_reg;
        node_next        = node_reg;
        w_next           = w_reg;
        x_node_next      = x_node_reg;
        x_w_next         = x_w_reg;
        p_next           = p_reg;
        l_next           = l_reg;
        le_node_next     = le_node_reg;
        le_w_next        = le_w_reg;
        has_r_next       = has_r_reg;
        root_node_next   = root_node_reg;
        res_status_next  = res_status_reg;
        res_node_next    = res_node_reg;
        res_w_next       = res_w_reg;
        res_present_next = res_present_reg;
        o_status_next    = o_status_reg;
        o_node_next      = o_node_reg;
        o_w_next         = o_w_reg;
        o_present_next   = o_present_reg;
        o_empty_next     = o_empty_reg;
        o_count_next     = o_count_reg;
        w_we    = 1'b0;
        w_waddr = node_idx;
        w_wdata = w_reg;
        w_raddr = node_idx;
        p_we    = 1'b0;
        p_waddr = x_node_reg;
        p_wdata = p_reg;
        p_raddr = node_idx;
        h_we    = 1'b0;
        h_waddr = p_minus1[NW-1:0];
        h_wdata = {x_node_reg, x_w_reg};
        h_raddr = p_minus1[NW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                w_we    = 1'b1;
                w_waddr = clr_reg;
                w_wdata = INF_WT;
                p_we    = 1'b1;
                p_waddr = clr_reg;
                p_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    node_next  = req.node;
                    w_next     = req.weight;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                // weight and position of the request node
                state_next = S_CHK;
            end
            S_CHK:
            begin
                res_node_next = node_reg;
                state_next    = S_DONE;
                priority if (func_reg == FUNC_POP)
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next  = ST_EMPTY;
                        res_w_next       = in_range ? w_rdata : 32'd0;
                        res_present_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_POP_A;
                    end
                end
                else if (!in_range)
                begin
                    res_status_next  = ST_ABSENT;
                    res_w_next       = 32'd0;
                    res_present_next = 1'b0;
                end
                else if (func_reg == FUNC_INSERT)
                begin
                    if (p_rdata != '0)
                    begin
                        res_status_next  = ST_PRESENT;
                        res_w_next       = w_rdata;
                        res_present_next = 1'b1;
                    end
                    else
                    begin
                        w_we             = 1'b1;
                        count_next       = count_reg + 1'b1;
                        p_next           = count_reg + 1'b1;
                        x_node_next      = node_idx;
                        x_w_next         = w_reg;
                        res_status_next  = ST_OK;
                        res_w_next       = w_reg;
                        res_present_next = 1'b1;
                        state_next       = S_UP_A;
                    end
                end
                else if (func_reg == FUNC_DECREASE)
                begin
                    if (p_rdata == '0)
                    begin
                        res_status_next  = ST_ABSENT;
                        res_w_next       = w_rdata;
                        res_present_next = 1'b0;
                    end
                    else if (!(w_reg < w_rdata))
                    begin
                        res_status_next  = ST_NOT_SMALLER;
                        res_w_next       = w_rdata;
                        res_present_next = 1'b1;
                    end
                    else
                    begin
                        w_we             = 1'b1;
                        p_next           = p_rdata;
                        x_node_next      = node_idx;
                        x_w_next         = w_reg;
                        res_status_next  = ST_OK;
                        res_w_next       = w_reg;
                        res_present_next = 1'b1;
                        state_next       = S_UP_A;
                    end
                end
                else
                begin
                    res_status_next  = ST_OK;
                    res_w_next       = w_rdata;
                    res_present_next = (p_rdata != '0);
                end
            end
            S_UP_A:
            begin
                // read the parent of the hole
                h_raddr = NW'(q_pos - 1'b1);
                if (p_reg == PW'(1))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_UP_B;
                end
            end
            S_UP_B:
            begin
                if (x_w_reg < hd_w)
                begin
                    // parent moves down into the hole
                    h_we       = 1'b1;
                    h_wdata    = h_rdata;
                    p_we       = 1'b1;
                    p_waddr    = hd_node;
                    p_next     = q_pos;
                    state_next = S_UP_A;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_POP_A:
            begin
                h_raddr    = '0;
                state_next = S_POP_B;
            end
            S_POP_B:
            begin
                // root captured, fetch the last entry
                h_raddr          = NW'(count_reg - 1'b1);
                root_node_next   = hd_node;
                res_status_next  = ST_OK;
                res_node_next    = hd_node8;
                res_w_next       = hd_w;
                res_present_next = 1'b0;
                state_next       = S_POP_C;
            end
            S_POP_C:
            begin
                x_node_next = hd_node;
                x_w_next    = hd_w;
                count_next  = count_reg - 1'b1;
                p_next      = PW'(1);
                if (count_reg == PW'(1))
                begin
                    state_next = S_POP_CLR;
                end
                else
                begin
                    state_next = S_DN_L;
                end
            end
            S_DN_L:
            begin
                h_raddr = NW'(l_pos - 1'b1);
                l_next  = l_pos;
                if (l_pos > count_wide)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                // left child captured, fetch the right one if it exists
                le_node_next = hd_node;
                le_w_next    = hd_w;
                h_raddr      = NW'(l_reg);
                has_r_next   = (r_pos <= count_wide);
                state_next   = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (s_w < x_w_reg)
                begin
                    // smaller child moves up into the hole
                    h_we       = 1'b1;
                    h_wdata    = {s_node, s_w};
                    p_we       = 1'b1;
                    p_waddr    = s_node;
                    p_next     = PW'(s_pos);
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                h_we    = 1'b1;
                p_we    = 1'b1;
                if (func_reg == FUNC_POP)
                begin
                    state_next = S_POP_CLR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_CLR:
            begin
                p_we       = 1'b1;
                p_waddr    = root_ext[NW-1:0];
                p_wdata    = '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = res_status_reg;
                    o_node_next    = res_node_reg;
                    o_w_next       = res_w_reg;
                    o_present_next = res_present_reg;
                    o_empty_next   = (count_reg == '0);
                    o_count_next   = count_ext[8:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        node_reg        <= node_next;
        w_reg           <= w_next;
        x_node_reg      <= x_node_next;
        x_w_reg         <= x_w_next;
        p_reg           <= p_next;
        l_reg           <= l_next;
        le_node_reg     <= le_node_next;
        le_w_reg        <= le_w_next;
        has_r_reg       <= has_r_next;
        root_node_reg   <= root_node_next;
        res_status_reg  <= res_status_next;
        res_node_reg    <= res_node_next;
        res_w_reg       <= res_w_next;
        res_present_reg <= res_present_next;
        o_status_reg    <= o_status_next;
        o_node_reg      <= o_node_next;
        o_w_reg         <= o_w_next;
        o_present_reg   <= o_present_next;
        o_empty_reg     <= o_empty_next;
        o_count_reg     <= o_count_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = o_status_reg;
    assign rsp.result_node   = o_node_reg;
    assign rsp.result_weight = o_w_reg;
    assign rsp.present       = o_present_reg;
    assign rsp.empty_res     = o_empty_reg;
    assign rsp.count         = o_count_reg;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed min-heap queue. A scoreboard model of
// the weight, heap and position stores predicts every result beat; bursty
// request traffic and a patterned, occasionally long, result stall exercise
// the handshake while inserts, decreases, pops and queries drive the heap.
// ----------------------------------------------------------------------------
module tb_top;
    import imhq_pkg::*;

    localparam int NNODES    = 256;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  node;
        logic [31:0] weight;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  node;
        logic [31:0] weight;
        logic        present;
        logic        empty_res;
        logic [8:0]  count;
    } rsp_t;

    logic clk;
    logic rst_n;

    imhq_in_if  req_ch ();
    imhq_out_if rsp_ch ();

    indexed_min_heap_queue_top #(.NODES(NNODES)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // scoreboard model of the queue
    logic [31:0] mdl_wt  [NNODES];
    logic [7:0]  mdl_heap[NNODES];
    int unsigned mdl_pos [NNODES];
    int unsigned mdl_cnt;

    req_t pending_q[$];
    rsp_t expected_q[$];

    int     n_errors      = 0;
    int     n_accepted    = 0;
    int     n_checked     = 0;
    int     n_pops        = 0;
    int     n_fail_status = 0;
    int     cycles        = 0;
    int     burst_left    = 0;
    int     gap_left      = 0;
    int     hold_left     = 0;
    int     holds_done    = 0;
    int     phase_ctr     = 0;
    int     max_cnt       = 0;

    // testbench clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] wt_at(int unsigned p);
        return mdl_wt[mdl_heap[p - 1]];
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [7:0] na;
        logic [7:0] nb;
        na = mdl_heap[a - 1];
        nb = mdl_heap[b - 1];
        mdl_heap[a - 1] = nb;
        mdl_heap[b - 1] = na;
        mdl_pos[nb] = a;
        mdl_pos[na] = b;
    endfunction

    function automatic void climb(int unsigned p);
        while (p > 1 && wt_at(p) < wt_at(p / 2))
        begin
            swap_slots(p, p / 2);
            p = p / 2;
        end
    endfunction

    function automatic void descend(int unsigned p);
        int unsigned l;
        int unsigned s;
        forever
        begin
            l = 2 * p;
            if (l > mdl_cnt)
                return;
            s = l;
            if (l + 1 <= mdl_cnt && wt_at(l + 1) < wt_at(l))
                s = l + 1;
            if (wt_at(s) < wt_at(p))
            begin
                swap_slots(p, s);
                p = s;
            end
            else
                return;
        end
    endfunction

    // apply one request to the model and return the expected result beat
    function automatic rsp_t heap_apply(req_t r);
        rsp_t o;
        logic [7:0] rn;
        rn = r.node;
        o.status = ST_OK;
        case (r.func)
            FUNC_POP:
            begin
                if (mdl_cnt == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    swap_slots(1, mdl_cnt);
                    rn = mdl_heap[mdl_cnt - 1];
                    mdl_cnt--;
                    descend(1);
                    mdl_pos[rn] = 0;
                end
            end
            FUNC_INSERT:
            begin
                if (mdl_pos[r.node] != 0)
                    o.status = ST_PRESENT;
                else
                begin
                    mdl_wt[r.node] = r.weight;
                    mdl_heap[mdl_cnt] = r.node;
                    mdl_cnt++;
                    mdl_pos[r.node] = mdl_cnt;
                    climb(mdl_cnt);
                end
            end
            FUNC_DECREASE:
            begin
                if (mdl_pos[r.node] == 0)
                    o.status = ST_ABSENT;
                else if (!(r.weight < mdl_wt[r.node]))
                    o.status = ST_NOT_SMALLER;
                else
                begin
                    mdl_wt[r.node] = r.weight;
                    climb(mdl_pos[r.node]);
                end
            end
            default: ;
        endcase
        o.node      = rn;
        o.weight    = mdl_wt[rn];
        o.present   = (mdl_pos[rn] != 0);
        o.empty_res = (mdl_cnt == 0);
        o.count     = mdl_cnt[8:0];
        return o;
    endfunction

    // stimulus helpers: pick a node from a small pool, or from anywhere
    function automatic logic [7:0] pick_node();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 39));
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 15));
            1: return INF_WT;
            2: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_req(logic [1:0] f, logic [7:0] n, logic [31:0] w);
        req_t r;
        r.func   = f;
        r.node   = n;
        r.weight = w;
        pending_q.push_back(r);
    endfunction

    // directed part, then random traffic
    initial
    begin
        int k;
        int mode;
        for (k = 0; k < NNODES; k++)
        begin
            mdl_wt[k]   = INF_WT;
            mdl_heap[k] = '0;
            mdl_pos[k]  = 0;
        end
        mdl_cnt = 0;

        // empty-queue pop, decrease and query of an absent node
        push_req(FUNC_POP, 8'd7, 32'd0);
        push_req(FUNC_DECREASE, 8'd7, 32'd1);
        push_req(FUNC_QUERY, 8'd255, 32'd0);
        // inserts with extreme nodes and weights
        push_req(FUNC_INSERT, 8'd0, INF_WT);
        push_req(FUNC_INSERT, 8'd255, 32'd0);
        push_req(FUNC_INSERT, 8'd128, 32'h8000_0000);
        push_req(FUNC_INSERT, 8'd3, 32'h8000_0000);
        push_req(FUNC_INSERT, 8'd0, 32'd5);
        // decrease: equal, not smaller, then valid
        push_req(FUNC_DECREASE, 8'd128, 32'h8000_0000);
        push_req(FUNC_DECREASE, 8'd128, INF_WT);
        push_req(FUNC_DECREASE, 8'd0, 32'hFFFF_FFFE);
        push_req(FUNC_DECREASE, 8'd3, 32'd0);
        push_req(FUNC_QUERY, 8'd3, 32'h5555_5555);
        // drain, then query a popped node and pop the empty queue
        for (k = 0; k < 5; k++)
            push_req(FUNC_POP, 8'($urandom_range(0, 255)), $urandom());
        push_req(FUNC_QUERY, 8'd255, 32'd0);
        push_req(FUNC_POP, 8'd170, 32'd0);
        push_req(FUNC_INSERT, 8'd85, 32'hAAAA_AAAA);
        push_req(FUNC_POP, 8'd0, 32'd0);

        // random: fill phases, churn phases, drain phases
        for (k = 0; k < 900; k++)
        begin
            mode = (k / 150) % 3;
            case ($urandom_range(0, 9))
                0, 1, 2:
                    push_req(FUNC_INSERT, pick_node(), pick_weight());
                3, 4:
                    push_req(mode == 2 ? FUNC_POP : FUNC_DECREASE, pick_node(),
                             pick_weight());
                5:
                    push_req(FUNC_QUERY, pick_node(), $urandom());
                6:
                    push_req(mode == 0 ? FUNC_INSERT : FUNC_POP, pick_node(),
                             pick_weight());
                default:
                    push_req(2'($urandom_range(0, 3)), pick_node(), $urandom());
            endcase
        end
        // a full-range fill so the heap gets deep
        for (k = 0; k < 256; k++)
            push_req(FUNC_INSERT, 8'(k), $urandom());
        for (k = 0; k < 40; k++)
            push_req(FUNC_DECREASE, 8'($urandom_range(0, 255)), 32'($urandom_range(0, 99)));
        for (k = 0; k < 260; k++)
            push_req(FUNC_POP, 8'(k), 32'd0);
    end

    // reset
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // request driver: bursts with random gaps, updated on the falling edge
    initial
    begin
        req_ch.valid  = 1'b0;
        req_ch.func   = FUNC_QUERY;
        req_ch.node   = '0;
        req_ch.weight = '0;
        rsp_ch.ready  = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_q.size() > 0)
                begin
                    req_ch.valid  <= 1'b1;
                    req_ch.func   <= pending_q[0].func;
                    req_ch.node   <= pending_q[0].node;
                    req_ch.weight <= pending_q[0].weight;
                end
            end
        end
    end

    // request acceptance and prediction at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            req_t r;
            r = pending_q.pop_front();
            expected_q.push_back(heap_apply(r));
            n_accepted++;
            if (mdl_cnt > max_cnt)
                max_cnt = mdl_cnt;
            if (expected_q[$].status != ST_OK)
                n_fail_status++;
            if (r.func == FUNC_POP)
                n_pops++;
            // next beat presented at the falling edge
            if (burst_left > 0 && pending_q.size() > 0)
            begin
                burst_left = burst_left - 1;
                @(negedge clk);
                req_ch.func   <= pending_q[0].func;
                req_ch.node   <= pending_q[0].node;
                req_ch.weight <= pending_q[0].weight;
            end
            else
            begin
                burst_left = $urandom_range(0, 12);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                @(negedge clk);
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result ready pattern, with two long hold-offs during the run
    always @(negedge clk)
    begin
        phase_ctr <= phase_ctr + 1;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if ((holds_done == 0 && n_accepted >= 300) ||
                 (holds_done == 1 && n_accepted >= 1100))
        begin
            hold_left    <= 2000;
            holds_done   <= holds_done + 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (phase_ctr[10])
            rsp_ch.ready <= 1'b1;
        else
            rsp_ch.ready <= ((phase_ctr % 7) < 4) || ($urandom_range(0, 1) == 1);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_t got;
            rsp_t exp_b;
            got.status    = rsp_ch.status;
            got.node      = rsp_ch.result_node;
            got.weight    = rsp_ch.result_weight;
            got.present   = rsp_ch.present;
            got.empty_res = rsp_ch.empty_res;
            got.count     = rsp_ch.count;
            if (expected_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result beat: st=%0d node=%0d", got.status, got.node);
            end
            else
            begin
                exp_b = expected_q.pop_front();
                n_checked++;
                if (got !== exp_b)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch beat %0d: exp st=%0d n=%0d w=%h p=%0d e=%0d c=%0d",
                                 n_checked, exp_b.status, exp_b.node, exp_b.weight,
                                 exp_b.present, exp_b.empty_res, exp_b.count,
                                 "\n              got st=%0d n=%0d w=%h p=%0d e=%0d c=%0d",
                                 got.status, got.node, got.weight, got.present,
                                 got.empty_res, got.count);
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        #1;
        wait (pending_q.size() == 0 && !req_ch.valid);
        wait (expected_q.size() == 0);
        repeat (100) @(posedge clk);
        $display("%0d requests checked, %0d pops, %0d error statuses, peak depth %0d",
                 n_checked, n_pops, n_fail_status, max_cnt);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches", n_errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
